// File: rtl/wzad_pkg.sv
// Package: window geometry, datapath widths, reset values and codes of the z-score detector.
`timescale 1ns / 1ps
package wzad_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int SMP_W        = 8;
  localparam int SMP_MAX      = (1 << SMP_W) - 1;
  localparam int SUM_W        = $clog2(WINDOW_DEPTH * SMP_MAX + 1);
  localparam int SQ_W         = $clog2(WINDOW_DEPTH * SMP_MAX * SMP_MAX + 1);
  // N*Q never exceeds (N*255)^2, so twice the sum width holds both N*Q and S*S
  localparam int D_W          = 2 * SUM_W;
  localparam int K_W          = 4;
  localparam int K2_W         = 2 * K_W;
  localparam int P_W          = D_W + K2_W;

  localparam logic [SMP_W-1:0] RESET_SAMPLE = SMP_W'(95);
  localparam logic [SUM_W-1:0] RESET_SUM    = SUM_W'(WINDOW_DEPTH * 95);
  localparam logic [SQ_W-1:0]  RESET_SQ     = SQ_W'(WINDOW_DEPTH * 95 * 95);
  localparam logic [K_W-1:0]   RESET_SIGMAS = K_W'(3);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_THRESHOLD_SIGMAS = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_STATS,
    ST_TEST
  } state_t;

endpackage

// File: rtl/wzad_in_if.sv
// Interface: input sample channel (valid/ready plus heart-rate payload).
`timescale 1ns / 1ps
interface wzad_in_if
  import wzad_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] heart_rate;

  modport source (output valid, output heart_rate, input ready);
  modport sink   (input valid, input heart_rate, output ready);
endinterface

// File: rtl/wzad_out_if.sv
// Interface: result channel (valid/ready plus anomaly flag).
`timescale 1ns / 1ps
interface wzad_out_if;
  logic valid;
  logic ready;
  logic anomaly;

  modport source (output valid, output anomaly, input ready);
  modport sink   (input valid, input anomaly, output ready);
endinterface

// File: rtl/window_zscore_anomaly_detector.sv
// Top level: sliding-window z-score anomaly detector for 8-bit heart-rate samples.
// Flow: each sample passes ring read, sum update, statistics and test; the result is
//   held in an output register until the sink takes it.
// The 4-step sequencer around the ring RAM takes a new sample only in its idle step.
// Reset: synchronous, active low; sums load 32*95 and 32*9025, pointer 0, threshold 3;
//   per-entry valid bits make unwritten ring entries read as 95, so there is no clearing pass.
`timescale 1ns / 1ps
module window_zscore_anomaly_detector
  import wzad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  wzad_in_if.sink               in_ch,
  wzad_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);
  // threshold in whole standard deviations; write only while idle (not enforced by the block)
  logic [K_W-1:0] sigmas;

  wzad_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .sigmas  (sigmas)
  );

  // core: ring RAM read-modify-write, exact sums, then
  // anomaly = (N*Q > S*S) && (N*x - S)^2 > k^2 * (N*Q - S*S)
  wzad_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .sigmas (sigmas),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );
endmodule

// File: rtl/wzad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wzad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/wzad_cfg.sv
// APB-style register port holding the threshold in standard deviations.
`timescale 1ns / 1ps
module wzad_cfg
  import wzad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [K_W-1:0]        sigmas
);
  logic [K_W-1:0] sigmas_r;
  logic [K_W-1:0] sigmas_nxt;
  logic           wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD_SIGMAS);

  always_comb begin
    sigmas_nxt = sigmas_r;
    if (wr_hit) begin
      sigmas_nxt = pwdata[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigmas_r <= RESET_SIGMAS;
    end else begin
      sigmas_r <= sigmas_nxt;
    end
  end

  // only one register, decoded on address bit 2: addresses with bit 2 set read as zero
  assign prdata = (paddr[2] == REG_THRESHOLD_SIGMAS) ?
                  {{(CFG_DATA_W-K_W){1'b0}}, sigmas_r} : '0;
  assign sigmas = sigmas_r;
endmodule

// File: rtl/wzad_core.sv
// Sequencer and datapath: ring read-modify-write, running sums and the integer z-score test.
`timescale 1ns / 1ps
module wzad_core
  import wzad_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic [K_W-1:0] sigmas,
  wzad_in_if.sink        in_ch,
  wzad_out_if.source     out_ch
);
  state_t                 state_r, state_nxt;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic [WINDOW_DEPTH-1:0] vld_r, vld_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [SMP_W-1:0]       x_r, x_nxt;
  logic [D_W-1:0]         d_r, d_nxt;
  logic                   pos_r, pos_nxt;
  logic [SUM_W-1:0]       dev_r, dev_nxt;
  logic [K2_W-1:0]        k2_r, k2_nxt;
  logic                   ovld_r, ovld_nxt;
  logic                   anom_r, anom_nxt;

  logic                   accept;
  logic                   ram_we;
  logic [SMP_W-1:0]       rd_data;
  logic [SMP_W-1:0]       old_smp;
  logic [D_W-1:0]         nq, ss, dev2;
  logic [SUM_W-1:0]       nx;
  logic [P_W-1:0]         kd;
  logic                   hit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign ram_we      = (state_r == ST_UPDATE);

  wzad_ram #(
    .WIDTH(SMP_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (x_r),
    .re    (accept),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  // entries never written read as the reset sample
  assign old_smp = vld_r[ptr_r] ? rd_data : RESET_SAMPLE;

  assign nq   = D_W'(sq_r) * D_W'(WINDOW_DEPTH);
  assign ss   = D_W'(sum_r) * D_W'(sum_r);
  assign nx   = SUM_W'(x_r) * SUM_W'(WINDOW_DEPTH);
  assign dev2 = D_W'(dev_r) * D_W'(dev_r);
  assign kd   = P_W'(k2_r) * P_W'(d_r);
  assign hit  = pos_r && (P_W'(dev2) > kd);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    vld_nxt   = vld_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    x_nxt     = x_r;
    d_nxt     = d_r;
    pos_nxt   = pos_r;
    dev_nxt   = dev_r;
    k2_nxt    = k2_r;
    anom_nxt  = anom_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt     = in_ch.heart_rate;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // intermediate wrap is harmless: the true sums fit the widths
        sum_nxt = sum_r - SUM_W'(old_smp) + SUM_W'(x_r);
        sq_nxt  = sq_r - SQ_W'(old_smp) * SQ_W'(old_smp) + SQ_W'(x_r) * SQ_W'(x_r);
        vld_nxt[ptr_r] = 1'b1;
        ptr_nxt = (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);
        state_nxt = ST_STATS;
      end
      ST_STATS: begin
        pos_nxt   = nq > ss;
        d_nxt     = nq - ss;
        dev_nxt   = (nx >= sum_r) ? (nx - sum_r) : (sum_r - nx);
        k2_nxt    = K2_W'(sigmas) * K2_W'(sigmas);
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        // hold here while the previous result is still unclaimed
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt  = 1'b1;
          anom_nxt  = hit;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
      vld_r   <= '0;
      sum_r   <= RESET_SUM;
      sq_r    <= RESET_SQ;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      vld_r   <= vld_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    d_r    <= d_nxt;
    pos_r  <= pos_nxt;
    dev_r  <= dev_nxt;
    k2_r   <= k2_nxt;
    anom_r <= anom_nxt;
  end

  assign out_ch.valid   = ovld_r;
  assign out_ch.anomaly = anom_r;
endmodule
